/* rtl/core/phone_dial_extension_selector_assert.svh */
// Assertion macros for the phone dial extension selector.
`ifndef PHONE_DIAL_EXTENSION_SELECTOR_ASSERT_SVH
`define PHONE_DIAL_EXTENSION_SELECTOR_ASSERT_SVH
`ifndef ASSERT_OFF
// Checked only outside reset.
`define PDES_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define PDES_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PDES_ASSERT(lbl, prop, msg)
`define PDES_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* rtl/core/pdes_pkg.sv */
// Shared types, register codes and constants of the extension selector.
`default_nettype none
package pdes_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TICK_MSECS    = 3'd0,
    CFG_DIGIT_GAP     = 3'd1,
    CFG_DIGIT_HOLD    = 3'd2,
    CFG_STARTUP_WAIT  = 3'd3,
    CFG_PULSE_ON_LVL  = 3'd4,
    CFG_PULSE_OFF_LVL = 3'd5,
    CFG_HOOK_ON_LVL   = 3'd6,
    CFG_HOOK_OFF_LVL  = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [4:0]  tick_msecs;
    logic [9:0]  digit_gap_msecs;
    logic [11:0] digit_hold_msecs;
    logic [13:0] startup_wait_msecs;
    logic [3:0]  pulse_on_level;
    logic [3:0]  pulse_off_level;
    logic [7:0]  hook_on_level;
    logic [7:0]  hook_off_level;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    tick_msecs:         5'd2,
    digit_gap_msecs:    10'd200,
    digit_hold_msecs:   12'd800,
    startup_wait_msecs: 14'd500,
    pulse_on_level:     4'd10,
    pulse_off_level:    4'd4,
    hook_on_level:      8'd150,
    hook_off_level:     8'd80
  };

  // Control beat from the top level to the rotary decoder.
  typedef struct packed {
    logic step;  // an item is being processed this cycle
    logic clr;   // on hook: clear rotary logic and pulse debouncer
    logic run;   // advance the rotary logic
  } rot_ctl_t;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_PULSE = 4'b0010,
    PH_SPACE = 4'b0100,
    PH_DONE  = 4'b1000
  } dial_phase_t;

  localparam logic [15:0] TIME_MAX      = 16'hFFFF;
  localparam logic [3:0]  PULSE_CNT_MAX = 4'd15;
  localparam logic [13:0] UPTIME_MAX    = 14'h3FFF;
  localparam logic [10:0] BLINK_PERIOD  = 11'd1000;
  localparam logic [9:0]  LED_ON1_END   = 10'd150;
  localparam logic [9:0]  LED_ON2_BEG   = 10'd300;
  localparam logic [9:0]  LED_ON2_END   = 10'd450;

  function automatic logic [15:0] sat_time_add(input logic [15:0] a, input logic [4:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {12'd0, b};
    return s[16] ? TIME_MAX : s[15:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/core/pdes_debounce.sv */
// Up/down integrating debouncer with hysteresis.
`default_nettype none
module pdes_debounce #(
  parameter int              W         = 4,
  parameter logic [W-1:0]    MAX_LEVEL = '1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step,
  input  logic         clr,
  input  logic         sample,
  input  logic [W-1:0] on_lv,
  input  logic [W-1:0] off_lv,
  output logic         state_nxt
);

  logic [W-1:0] level_r, level_nxt;
  logic         state_r;

  always_comb begin
    if (sample) begin
      level_nxt = (level_r < MAX_LEVEL) ? level_r + 1'b1 : MAX_LEVEL;
    end else begin
      level_nxt = (level_r != '0) ? level_r - 1'b1 : '0;
    end
    state_nxt = !state_r ? (level_nxt >= on_lv) : !(level_nxt <= off_lv);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
      state_r <= 1'b0;
    end else if (step) begin
      if (clr) begin
        level_r <= '0;
        state_r <= 1'b0;
      end else begin
        level_r <= level_nxt;
        state_r <= state_nxt;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/pdes_rotary.sv */
// Rotary dial decoder: pulse debouncer, pulse counter, gap and hold timers.
`default_nettype none
module pdes_rotary #(
  parameter logic [3:0] PULSE_MAX = 4'd15
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pdes_pkg::rot_ctl_t ctl,
  input  pdes_pkg::cfg_t    cfg,
  input  logic              pulse_raw,
  output logic [3:0]        ext
);
  import pdes_pkg::*;

  logic        p;
  dial_phase_t phase_r, phase_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [15:0] on_r, on_nxt;
  logic [15:0] off_r, off_nxt;
  logic [15:0] hold_r, hold_nxt;

  pdes_debounce #(.W(4), .MAX_LEVEL(PULSE_MAX)) u_pulse_db (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (ctl.step && (ctl.run || ctl.clr)),
    .clr       (ctl.clr),
    .sample    (pulse_raw),
    .on_lv     (cfg.pulse_on_level),
    .off_lv    (cfg.pulse_off_level),
    .state_nxt (p)
  );

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    on_nxt    = on_r;
    off_nxt   = off_r;
    hold_nxt  = hold_r;
    ext       = '0;
    if (p) begin
      // a new pulse after idle or a finished digit starts a fresh digit
      if (phase_r inside {PH_IDLE, PH_DONE}) begin
        cnt_nxt  = '0;
        hold_nxt = '0;
        on_nxt   = '0;
      end
      phase_nxt = PH_PULSE;
      off_nxt   = '0;
      on_nxt    = sat_time_add(on_nxt, cfg.tick_msecs);
    end else if (phase_r inside {PH_PULSE, PH_SPACE}) begin
      phase_nxt = PH_SPACE;
      if (on_r != '0) begin
        on_nxt = '0;
        if (cnt_r != PULSE_CNT_MAX) begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      off_nxt = sat_time_add(off_r, cfg.tick_msecs);
      if (off_nxt > {6'd0, cfg.digit_gap_msecs}) begin
        phase_nxt = PH_DONE;
        hold_nxt  = {4'd0, cfg.digit_hold_msecs};
      end
    end
    if (phase_nxt == PH_DONE && hold_nxt != '0) begin
      if (hold_nxt <= {11'd0, cfg.tick_msecs}) begin
        phase_nxt = PH_IDLE;
        cnt_nxt   = '0;
        on_nxt    = '0;
        off_nxt   = '0;
        hold_nxt  = '0;
      end else begin
        hold_nxt = hold_nxt - {11'd0, cfg.tick_msecs};
        ext      = cnt_nxt;
      end
    end
    if (!ctl.run) begin
      ext = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      on_r    <= '0;
      off_r   <= '0;
      hold_r  <= '0;
    end else if (ctl.step) begin
      if (ctl.clr) begin
        phase_r <= PH_IDLE;
        cnt_r   <= '0;
        on_r    <= '0;
        off_r   <= '0;
        hold_r  <= '0;
      end else if (ctl.run) begin
        phase_r <= phase_nxt;
        cnt_r   <= cnt_nxt;
        on_r    <= on_nxt;
        off_r   <= off_nxt;
        hold_r  <= hold_nxt;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/phone_dial_extension_selector.sv */
// Top level of the phone dial extension selector.
//
// Each input beat is one timer tick of tick_msecs milliseconds carrying raw
// hook, rotary pulse, tone valid and tone code samples. Each accepted beat
// yields exactly one result beat: selected extension, lamp drive and
// debounced hook state.
// Path: a beat accepted at one edge lands in the input register, and its
// result is loaded into the output register at the next advancing edge,
// which raises out_valid.
// Throughput: one beat per cycle while out_ready is high; the tick update
// is a single pass of short logic between the input and result registers.
// Stall: while out_ready is low the result register holds; one more beat can
// still sit in the input register, after which in_ready drops.
// Reset (rst_n low at a clock edge) empties both registers, clears all
// debouncer, dial, uptime and blink state, and loads the default settings.
// Configuration: cfg_ready is always high; write settings only while idle.
`default_nettype none
`include "phone_dial_extension_selector_assert.svh"
module phone_dial_extension_selector #(
  parameter int PULSE_LEVEL_MAX = 15,
  parameter int HOOK_LEVEL_MAX  = 200,
  parameter int UPTIME_CAP      = 10000
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_hook_raw,
  input  logic                            in_pulse_raw,
  input  logic                            in_tone_valid,
  input  logic [3:0]                      in_tone_code,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [3:0]                      out_selected_extension,
  output logic                            out_lamp,
  output logic                            out_on_hook,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pdes_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pdes_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pdes_pkg::*;

  localparam logic [3:0]  PULSE_MAX = (PULSE_LEVEL_MAX > 15) ? 4'd15 : 4'(PULSE_LEVEL_MAX);
  localparam logic [7:0]  HOOK_MAX  = (HOOK_LEVEL_MAX > 255) ? 8'd255 : 8'(HOOK_LEVEL_MAX);
  localparam logic [13:0] UP_CAP    = 14'(UPTIME_CAP);

  cfg_t cfg_r;

  // input register
  logic       s0_valid_r;
  logic       s0_hook_r, s0_pulse_r, s0_tvalid_r;
  logic [3:0] s0_tcode_r;

  // result register
  logic       out_valid_r;
  logic [3:0] out_ext_r;
  logic       out_led_r, out_hook_r;

  // tick-wide state
  logic [13:0] uptime_r, uptime_nxt;
  logic [9:0]  blink_r, blink_nxt;

  logic       advance, fire;
  logic       hook_st;
  logic       tone_hit;
  logic       led_nxt;
  logic [3:0] rot_ext, ext_nxt;
  logic [10:0] blink_sum;
  logic [14:0] uptime_sum;
  rot_ctl_t   rot_ctl;

  assign advance   = !out_valid_r || out_ready;
  assign fire      = s0_valid_r && advance;
  assign in_ready  = !s0_valid_r || advance;
  assign cfg_ready = 1'b1;

  // Write one setting, masked to its width.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TICK_MSECS:    cfg_r.tick_msecs         <= cfg_data[4:0];
        CFG_DIGIT_GAP:     cfg_r.digit_gap_msecs    <= cfg_data[9:0];
        CFG_DIGIT_HOLD:    cfg_r.digit_hold_msecs   <= cfg_data[11:0];
        CFG_STARTUP_WAIT:  cfg_r.startup_wait_msecs <= cfg_data[13:0];
        CFG_PULSE_ON_LVL:  cfg_r.pulse_on_level     <= cfg_data[3:0];
        CFG_PULSE_OFF_LVL: cfg_r.pulse_off_level    <= cfg_data[3:0];
        CFG_HOOK_ON_LVL:   cfg_r.hook_on_level      <= cfg_data[7:0];
        CFG_HOOK_OFF_LVL:  cfg_r.hook_off_level     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Capture an accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_ready) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_hook_r   <= in_hook_raw;
      s0_pulse_r  <= in_pulse_raw;
      s0_tvalid_r <= in_tone_valid;
      s0_tcode_r  <= in_tone_code;
    end
  end

  // Hook debouncer sees every tick and is never cleared.
  pdes_debounce #(.W(8), .MAX_LEVEL(HOOK_MAX)) u_hook_db (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (fire),
    .clr       (1'b0),
    .sample    (s0_hook_r),
    .on_lv     (cfg_r.hook_on_level),
    .off_lv    (cfg_r.hook_off_level),
    .state_nxt (hook_st)
  );

  // A tone key wins over the dial; the dial waits out the power-up time.
  assign tone_hit     = s0_tvalid_r && (s0_tcode_r != 4'd0);
  assign rot_ctl.step = fire;
  assign rot_ctl.clr  = hook_st;
  assign rot_ctl.run  = !hook_st && !tone_hit && (uptime_r >= cfg_r.startup_wait_msecs);

  pdes_rotary #(.PULSE_MAX(PULSE_MAX)) u_rotary (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (rot_ctl),
    .cfg       (cfg_r),
    .pulse_raw (s0_pulse_r),
    .ext       (rot_ext)
  );

  always_comb begin
    if (hook_st) begin
      ext_nxt = '0;
    end else if (tone_hit) begin
      ext_nxt = s0_tcode_r;
    end else begin
      ext_nxt = rot_ext;
    end
  end

  // Blink phase wraps once a second; the sum stays below twice the period.
  always_comb begin
    blink_sum = {1'b0, blink_r} + {6'd0, cfg_r.tick_msecs};
    if (hook_st) begin
      blink_nxt = '0;
    end else if (blink_sum >= BLINK_PERIOD) begin
      blink_nxt = 10'(blink_sum - BLINK_PERIOD);
    end else begin
      blink_nxt = blink_sum[9:0];
    end
    led_nxt = !hook_st && ((blink_nxt <= LED_ON1_END) ||
                           (blink_nxt >= LED_ON2_BEG && blink_nxt <= LED_ON2_END));
  end

  // Uptime stops once it reaches the cap; clamp at the register's full scale.
  always_comb begin
    uptime_sum = {1'b0, uptime_r} + {10'd0, cfg_r.tick_msecs};
    if (uptime_r >= UP_CAP) begin
      uptime_nxt = uptime_r;
    end else if (uptime_sum[14]) begin
      uptime_nxt = UPTIME_MAX;
    end else begin
      uptime_nxt = uptime_sum[13:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      uptime_r <= '0;
      blink_r  <= '0;
    end else if (fire) begin
      uptime_r <= uptime_nxt;
      blink_r  <= blink_nxt;
    end
  end

  // Result register: load on fire, drop valid once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s0_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_ext_r  <= ext_nxt;
      out_led_r  <= led_nxt;
      out_hook_r <= hook_st;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_selected_extension = out_ext_r;
  assign out_lamp               = out_led_r;
  assign out_on_hook            = out_hook_r;

  `PDES_ASSERT(a_hook_no_ext, out_valid_r && out_hook_r |-> out_ext_r == 4'd0, "ext on hook")
  `PDES_ASSERT(a_hook_no_led, out_valid_r && out_hook_r |-> !out_led_r, "lamp lit on hook")
  `PDES_ASSERT(a_accept_loads, in_valid && in_ready |=> s0_valid_r, "accepted beat lost")
  `PDES_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid_r && !s0_valid_r, "not empty")

endmodule
`default_nettype wire
